// File: design/homogeneity_edge_detector_3x3_macros.svh
// Assertion macros used by the top level of the homogeneity edge detector.
`ifndef HOMOGENEITY_EDGE_DETECTOR_3X3_MACROS_SVH
`define HOMOGENEITY_EDGE_DETECTOR_3X3_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define HED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hed_pkg.sv
// Types, constants and helper functions of the homogeneity edge detector.
`default_nettype none

package hed_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int PIX_BITS     = 3 * CHANNEL_BITS;
    localparam int SUM_W        = CHANNEL_BITS + 2;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;

    localparam int ROW_W        = CFG_HEIGHT_W + 1;
    localparam int OUT_ROW_W    = CFG_HEIGHT_W;

    localparam int WIN_SIZE      = 9;
    localparam int CENTER        = 4;
    localparam int NUM_NEIGHBORS = 8;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } hed_cfg_idx_t;

    typedef logic [CHANNEL_BITS-1:0] hed_chan_t;
    typedef logic [SUM_W-1:0]        hed_sum_t;

    typedef struct packed {
        hed_chan_t blue;
        hed_chan_t green;
        hed_chan_t red;
    } hed_rgb_t;

    typedef struct packed {
        logic      is_flush;
        hed_chan_t pixel_blue;
        hed_chan_t pixel_green;
        hed_chan_t pixel_red;
    } hed_pixel_t;

    typedef struct packed {
        hed_chan_t edge_blue;
        hed_chan_t edge_green;
        hed_chan_t edge_red;
        logic      last_of_frame;
    } hed_edge_t;

    // Frame-boundary status of one centre pixel.
    typedef struct packed {
        logic last;
        logic top_out;
        logic bottom_out;
        logic left_out;
        logic right_out;
    } hed_ctl_t;

    function automatic hed_chan_t abs_diff(input hed_chan_t a, input hed_chan_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// File: design/hed_stream_if.sv
// Valid/ready stream interface used for the pixel and edge channels.
`default_nettype none

interface hed_stream_if
    import hed_pkg::*;
#(
    parameter type payload_t = hed_pixel_t
)
();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/hed_line_buf.sv
// Two-row line memory with a registered read and same-address bypass.
`default_nettype none

module hed_line_buf
    import hed_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 2 * PIX_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [DATA_W-1:0]          wr_data,
    output logic [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_q_reg;
    logic [DATA_W-1:0] bypass_data_reg;
    logic              bypass_sel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg       <= mem[rd_addr];
            bypass_data_reg <= wr_data;
        end
    end

    // A write to the address being read in the same cycle wins over the old word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_sel_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            bypass_sel_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = bypass_sel_reg ? bypass_data_reg : mem_q_reg;

endmodule

`default_nettype wire

// File: design/hed_select.sv
// Neighbor difference stage and first-maximum selection tree.
`default_nettype none

module hed_select
    import hed_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  hed_ctl_t                  in_ctl,
    input  hed_rgb_t [WIN_SIZE-1:0]   window,
    output logic                      out_valid,
    output hed_edge_t                 out_edge
);

    hed_rgb_t [NUM_NEIGHBORS-1:0] diff_next;
    hed_rgb_t [NUM_NEIGHBORS-1:0] diff_reg;
    hed_sum_t [NUM_NEIGHBORS-1:0] sum_next;
    hed_sum_t [NUM_NEIGHBORS-1:0] sum_reg;
    logic                         valid_reg;
    logic                         last_reg;

    hed_rgb_t [3:0] l1_diff;
    hed_sum_t [3:0] l1_sum;
    hed_rgb_t [1:0] l2_diff;
    hed_sum_t [1:0] l2_sum;
    hed_rgb_t       best_diff;

    // Neighbors outside the frame read as black. The centre is left out: its
    // difference is zero and it can never be the strict maximum.
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int K = r * 3 + c;
            if (K != CENTER)
            begin : g_nb
                localparam int J = (K < CENTER) ? K : K - 1;
                logic     off;
                hed_rgb_t nb;

                assign off = ((r == 0) && in_ctl.top_out)  || ((r == 2) && in_ctl.bottom_out)
                          || ((c == 0) && in_ctl.left_out) || ((c == 2) && in_ctl.right_out);
                assign nb  = off ? '0 : window[K];

                assign diff_next[J].blue  = abs_diff(nb.blue,  window[CENTER].blue);
                assign diff_next[J].green = abs_diff(nb.green, window[CENTER].green);
                assign diff_next[J].red   = abs_diff(nb.red,   window[CENTER].red);
                assign sum_next[J] = SUM_W'(diff_next[J].blue) + SUM_W'(diff_next[J].green)
                                   + SUM_W'(diff_next[J].red);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sum_reg  <= sum_next;
        last_reg <= in_ctl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Ties go to the earlier neighbor, so the tree returns the first maximum.
    // An all-zero maximum yields an all-zero difference by itself.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (sum_reg[2*i+1] > sum_reg[2*i])
            begin
                l1_sum[i]  = sum_reg[2*i+1];
                l1_diff[i] = diff_reg[2*i+1];
            end
            else
            begin
                l1_sum[i]  = sum_reg[2*i];
                l1_diff[i] = diff_reg[2*i];
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (l1_sum[2*i+1] > l1_sum[2*i])
            begin
                l2_sum[i]  = l1_sum[2*i+1];
                l2_diff[i] = l1_diff[2*i+1];
            end
            else
            begin
                l2_sum[i]  = l1_sum[2*i];
                l2_diff[i] = l1_diff[2*i];
            end
        end
        best_diff = (l2_sum[1] > l2_sum[0]) ? l2_diff[1] : l2_diff[0];
    end

    assign out_valid              = valid_reg;
    assign out_edge.edge_blue     = best_diff.blue;
    assign out_edge.edge_green    = best_diff.green;
    assign out_edge.edge_red      = best_diff.red;
    assign out_edge.last_of_frame = last_reg;

endmodule

`default_nettype wire

// File: design/homogeneity_edge_detector_3x3.sv
// Top level of the 3x3 homogeneity edge detector for RGB pixel streams.
// Usage: pixels enter on pixel_in in raster order, one request per pixel; each
// result leaves on edge_out as the absolute RGB difference of the neighbor that
// differs most from the centre. Both channels use a valid/ready handshake.
// The result for a centre needs its full neighborhood, so it is released by the
// request that arrives W+1 positions later; after the W*H pixels of a frame the
// source sends W+1 flush requests to drain the last row. The last result of the
// frame carries last_of_frame, and the next request starts a new frame.
// A result passes the line memory read, window, difference and queue registers.
// Throughput is one request per clock while pixel_in.ready is high, bounded by
// the single read and single write per cycle of the two-row line memory.
// Results wait in an 8-entry output queue; when queued plus in-flight results
// reach 8, pixel_in.ready drops, so a stalled receiver never loses a result.
// Reset clears the frame position and the queue and sets the geometry to
// 640 x 480. The line memory is not cleared: reads outside the frame are masked.
// A write on the configuration port restarts the frame at its first pixel.
`default_nettype none
`include "homogeneity_edge_detector_3x3_macros.svh"

module homogeneity_edge_detector_3x3
    import hed_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    hed_stream_if.sink             pixel_in,
    hed_stream_if.source           edge_out,
    input  logic                   cfg_we,
    input  hed_cfg_idx_t           cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);

    // Geometry registers and their effective values.
    logic [CFG_WIDTH_W-1:0]  frame_width_reg;
    logic [CFG_HEIGHT_W-1:0] frame_height_reg;
    logic [WID_W-1:0]        eff_width;
    logic [WID_W-1:0]        width_last;
    logic [CFG_HEIGHT_W-1:0] eff_height;
    logic [CFG_HEIGHT_W-1:0] height_last;

    // Stream position of the next request and position of the next centre.
    logic [COL_W-1:0]     in_col_reg,  in_col_next;
    logic [ROW_W-1:0]     in_row_reg,  in_row_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;

    logic     accept;
    logic     in_frame;
    logic     produce;
    logic     in_col_end;
    logic     out_col_end;
    logic     out_row_end;
    logic     frame_done;
    hed_ctl_t ctl;
    hed_rgb_t pix_in;

    // Stage 1: line memory read in flight.
    logic             s1_valid_reg;
    logic             s1_produce_reg;
    hed_ctl_t         s1_ctl_reg;
    hed_rgb_t         s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;

    logic [2*PIX_BITS-1:0] line_rd;
    logic [2*PIX_BITS-1:0] line_wr;
    hed_rgb_t              line_mid;
    hed_rgb_t              line_top;

    // Stage 2: 3x3 window, index row * 3 + column.
    hed_rgb_t [WIN_SIZE-1:0] win_reg;
    logic                    s2_valid_reg;
    hed_ctl_t                s2_ctl_reg;

    logic      sel_valid;
    hed_edge_t sel_edge;

    // Output queue.
    hed_edge_t             fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] fifo_wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] fifo_rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_count_reg;
    logic [FIFO_CNT_W-1:0] occupancy;
    logic                  pop;

    // A zero width or height acts as one; a width above the line memory is clipped.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_width = WID_W'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_width = WID_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WID_W'(frame_width_reg);
        end
        eff_height = (frame_height_reg == '0) ? CFG_HEIGHT_W'(1) : frame_height_reg;
    end

    assign width_last  = eff_width - WID_W'(1);
    assign height_last = eff_height - CFG_HEIGHT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
            endcase
        end
    end

    assign accept = pixel_in.valid && pixel_in.ready;

    // Requests past the last row, and flush requests, enter the history as black.
    assign in_frame   = in_row_reg < ROW_W'(eff_height);
    assign in_col_end = WID_W'(in_col_reg) == width_last;
    assign pix_in     = (!pixel_in.payload.is_flush && in_frame)
                      ? {pixel_in.payload.pixel_blue, pixel_in.payload.pixel_green,
                         pixel_in.payload.pixel_red}
                      : '0;

    // A centre is complete once the request W+1 positions after it arrives.
    assign produce = (in_row_reg >= ROW_W'(2))
                  || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

    assign out_col_end = WID_W'(out_col_reg) == width_last;
    assign out_row_end = out_row_reg == height_last;

    assign ctl.last       = out_col_end && out_row_end;
    assign ctl.top_out    = out_row_reg == '0;
    assign ctl.bottom_out = out_row_end;
    assign ctl.left_out   = out_col_reg == '0;
    assign ctl.right_out  = out_col_end;

    assign frame_done = produce && ctl.last;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we || (accept && frame_done))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (in_col_end)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (produce)
            begin
                if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OUT_ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Each column address holds the two older pixels of that column: the word
    // read for a request gives the pixels one and two rows above it, and the
    // word written back shifts the new pixel in.
    hed_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIX_BITS)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    assign line_mid = line_rd[2*PIX_BITS-1:PIX_BITS];
    assign line_top = line_rd[PIX_BITS-1:0];
    assign line_wr  = {s1_pix_reg, line_mid};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl;
            s1_pix_reg <= pix_in;
            s1_col_reg <= in_col_reg;
        end
    end

    // Window columns shift left by one per request; the new column enters on the right.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= line_top;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= line_mid;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= s1_pix_reg;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_produce_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= accept;
            s1_produce_reg <= accept && produce;
            s2_valid_reg   <= s1_valid_reg && s1_produce_reg;
        end
    end

    hed_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_ctl    (s2_ctl_reg),
        .window    (win_reg),
        .out_valid (sel_valid),
        .out_edge  (sel_edge)
    );

    // Credit check: every result still in the pipeline has a reserved queue slot.
    assign occupancy = fifo_count_reg
                     + FIFO_CNT_W'(s1_valid_reg && s1_produce_reg)
                     + FIFO_CNT_W'(s2_valid_reg)
                     + FIFO_CNT_W'(sel_valid);
    assign pixel_in.ready = occupancy < FIFO_CNT_W'(FIFO_DEPTH);

    assign pop              = edge_out.valid && edge_out.ready;
    assign edge_out.valid   = fifo_count_reg != '0;
    assign edge_out.payload = fifo_mem_reg[fifo_rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (sel_valid)
        begin
            fifo_mem_reg[fifo_wr_ptr_reg] <= sel_edge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_count_reg  <= '0;
        end
        else
        begin
            if (sel_valid)
            begin
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + FIFO_PTR_W'(1);
            end
            fifo_count_reg <= fifo_count_reg + FIFO_CNT_W'(sel_valid) - FIFO_CNT_W'(pop);
        end
    end

    `HED_ASSERT_NOW(a_queue_no_overflow, sel_valid, (fifo_count_reg != FIFO_CNT_W'(FIFO_DEPTH)) || pop, "result pushed into a full output queue")
    `HED_ASSERT_NEXT(a_accept_enters_pipe, accept, s1_valid_reg, "accepted request did not enter the pipeline")
    `HED_ASSERT_NEXT(a_frame_restart, accept && frame_done && !cfg_we, (in_row_reg == '0) && (in_col_reg == '0) && (out_row_reg == '0) && (out_col_reg == '0), "frame position not restarted after last result")

endmodule

`default_nettype wire
